// ===== src/lru_page_slot_cache_defines.svh =====
// Assertion macros for the LRU page slot cache.
// Used by modules that include this header; expects i_clk and i_rst_n in scope.
`ifndef LRU_PAGE_SLOT_CACHE_DEFINES_SVH
`define LRU_PAGE_SLOT_CACHE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LPSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lpsc_pkg.sv =====
// Shared constants, codes and types of the LRU page slot cache.
// No dependencies; imported by the interfaces, the cell and the top level.
package lpsc_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int LVL_N    = $clog2(CAPACITY);

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int FRAME_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OSLOT_W  = 6;
    localparam int CFG_W    = 7;
    localparam int CMP_W    = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int REG_W    = APB_AW - 2;

    localparam logic [CFG_W-1:0] MAX_PAGES_RST = 7'd64;
    localparam logic [REG_W-1:0] REG_MAX_PAGES = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_INSERT  = 2'd1,
        CMD_TOUCH   = 2'd2,
        CMD_EVICT_Q = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_MISS = 2'd0,
        ST_HIT  = 2'd1,
        ST_NEW  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef struct packed {
        logic             load;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

endpackage

// ===== src/lpsc_req_if.sv =====
// Request channel of the LRU page slot cache: valid/ready plus command fields.
// Depends on lpsc_pkg.
interface lpsc_req_if;
    import lpsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [KEY_W-1:0]   page_key;
    logic [FRAME_W-1:0] frame_index;

    modport source (output valid, command, page_key, frame_index, input ready);
    modport sink   (input valid, command, page_key, frame_index, output ready);
endinterface

// ===== src/lpsc_rsp_if.sv =====
// Response channel of the LRU page slot cache: valid/ready plus result fields.
// Depends on lpsc_pkg.
interface lpsc_rsp_if;
    import lpsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OSLOT_W-1:0]  slot;
    logic [KEY_W-1:0]    entry_key;
    logic [FRAME_W-1:0]  last_frame;

    modport source (output valid, status, slot, entry_key, last_frame, input ready);
    modport sink   (input valid, status, slot, entry_key, last_frame, output ready);
endinterface

// ===== src/lpsc_cell.sv =====
// One position of the recency chain: entry storage, valid bit and key compare.
// Depends on lpsc_pkg.
module lpsc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpsc_pkg::t_cell_ctl i_ctl,
    input  logic               i_up_valid,
    input  lpsc_pkg::t_entry   i_up,
    output logic               o_valid,
    output lpsc_pkg::t_entry   o_ent,
    output logic               o_hit
);
    import lpsc_pkg::*;

    logic   r_valid;
    t_entry r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ent <= i_up;
        end
    end

    assign o_valid = r_valid;
    assign o_ent   = r_ent;
    assign o_hit   = r_valid && (r_ent.key == i_ctl.key);
endmodule

// ===== src/lru_page_slot_cache.sv =====
// Top level of the LRU page slot cache: a shifting chain of lpsc_cell entries.
// Depends on lpsc_pkg, lpsc_req_if, lpsc_rsp_if, lpsc_cell and the defines header.
//
//   port      dir   protocol    payload
//   i_req     in    valid/ready command, page_key, frame_index
//   o_rsp     out   valid/ready status, slot, entry_key, last_frame
//   APB       in    psel/penable max_pages at byte address 0
//
// Each request beat passes through a compare cycle over all cells, then a shift cycle.
// The shift cycle waits while the result register holds an untaken beat.
// Reset clears all valid bits and the fill count at once; no clearing pass.
// A request is taken while the previous result still waits on o_rsp.
`include "lru_page_slot_cache_defines.svh"

module lru_page_slot_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lpsc_req_if.sink                      i_req,
    lpsc_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpsc_pkg::APB_AW-1:0]   paddr,
    input  logic [lpsc_pkg::APB_DW-1:0]   pwdata,
    output logic [lpsc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lpsc_pkg::*;

    typedef enum logic [1:0] {
        S_ACC = 2'b01,
        S_UPD = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_max_pages;
    logic [FILL_W-1:0]  r_filled;
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [FRAME_W-1:0] r_frame;
    logic               r_hit;
    logic               r_free;
    logic               r_empty;
    logic               r_do_shift;
    logic [CAPACITY-1:0] r_sel;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [OSLOT_W-1:0]  r_out_slot;
    logic [KEY_W-1:0]    r_out_key;
    logic [FRAME_W-1:0]  r_out_frame;

    logic [STATUS_W-1:0] n_out_status;
    logic [OSLOT_W-1:0]  n_out_slot;
    logic [KEY_W-1:0]    n_out_key;
    logic [FRAME_W-1:0]  n_out_frame;
    logic [CAPACITY-1:0] n_sel;
    logic                n_do_shift;

    logic [CAPACITY-1:0] w_valid, w_hit, w_first_inv, w_last_val, w_mask, w_up_valid;
    t_entry              w_ent [CAPACITY];
    t_entry              w_up [CAPACITY];
    t_cell_ctl           w_ctl [CAPACITY];
    logic [ENT_W-1:0]    w_pick_bits;
    t_entry              w_pick;
    t_entry              w_new;
    t_cmd                w_cmd;
    logic [CMP_W-1:0]    w_eff;
    logic [CMP_W-1:0]    w_cfg_ext;
    logic                w_any_hit, w_free, w_acc, w_adv, w_cfg_wr;
    logic [REG_W-1:0]    w_reg;

    // configuration port
    assign pready   = 1'b1;
    assign w_reg    = paddr[APB_AW-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pages <= MAX_PAGES_RST;
        end else if (w_cfg_wr && (w_reg == REG_MAX_PAGES)) begin
            r_max_pages <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        case (w_reg)
            REG_MAX_PAGES: prdata = APB_DW'(r_max_pages);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg_ext = CMP_W'(r_max_pages);
        if (w_cfg_ext == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_cfg_ext > CMP_W'(CAPACITY)) begin
            w_eff = CMP_W'(CAPACITY);
        end else begin
            w_eff = w_cfg_ext;
        end
    end

    // chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_up_valid[g]  = 1'b1;
            assign w_up[g]        = w_new;
            assign w_first_inv[g] = !w_valid[g];
        end else begin : g_body
            assign w_up_valid[g]  = w_valid[g-1];
            assign w_up[g]        = w_ent[g-1];
            assign w_first_inv[g] = !w_valid[g] && w_valid[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_last_val[g] = w_valid[g];
        end else begin : g_mid
            assign w_last_val[g] = w_valid[g] && !w_valid[g+1];
        end

        assign w_ctl[g] = '{load: w_adv && r_do_shift && w_mask[g], key: i_req.page_key};

        lpsc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_up_valid (w_up_valid[g]),
            .i_up       (w_up[g]),
            .o_valid    (w_valid[g]),
            .o_ent      (w_ent[g]),
            .o_hit      (w_hit[g])
        );
    end

    // compare cycle: pick the chain position to act on
    assign w_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_ACC);
    assign w_cmd     = t_cmd'(i_req.command);
    assign w_any_hit = |w_hit;
    assign w_free    = CMP_W'(r_filled) < w_eff;

    always_comb begin
        case (w_cmd)
            CMD_EVICT_Q: n_sel = w_last_val;
            CMD_INSERT:  n_sel = w_any_hit ? w_hit : (w_free ? w_first_inv : w_last_val);
            default:     n_sel = w_hit;
        endcase
        n_do_shift = (w_cmd != CMD_EVICT_Q) && (w_any_hit || (w_cmd == CMD_INSERT));
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd      <= w_cmd;
            r_key      <= i_req.page_key;
            r_frame    <= i_req.frame_index;
            r_hit      <= w_any_hit && (w_cmd != CMD_EVICT_Q);
            r_free     <= w_free;
            r_empty    <= (r_filled == '0);
            r_sel      <= n_sel;
            r_do_shift <= n_do_shift;
        end
    end

    // shift cycle
    assign w_adv = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        w_pick_bits = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_pick_bits = w_pick_bits | ({ENT_W{r_sel[i]}} & w_ent[i]);
        end
    end
    assign w_pick = t_entry'(w_pick_bits);

    // shift every position from the head (position 0) up to and including the selected one
    always_comb begin
        w_mask = r_sel;
        for (int l = 0; l < LVL_N; l++) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (i + (1 << l) < CAPACITY) begin
                    w_mask[i] = w_mask[i] | w_mask[i + (1 << l)];
                end
            end
        end
    end

    always_comb begin
        w_new.key   = r_hit ? w_pick.key : r_key;
        w_new.slot  = (!r_hit && r_free) ? SLOT_W'(r_filled) : w_pick.slot;
        w_new.frame = (r_cmd == CMD_LOOKUP) ? w_pick.frame : r_frame;
    end

    always_comb begin
        n_out_status = ST_MISS;
        n_out_slot   = '0;
        n_out_key    = '0;
        n_out_frame  = '0;
        if (r_do_shift) begin
            n_out_status = r_hit ? ST_HIT : ST_NEW;
            n_out_slot   = OSLOT_W'(w_new.slot);
            n_out_key    = w_new.key;
            n_out_frame  = w_new.frame;
        end else if ((r_cmd == CMD_EVICT_Q) && !r_empty) begin
            n_out_status = ST_HIT;
            n_out_slot   = OSLOT_W'(w_pick.slot);
            n_out_key    = w_pick.key;
            n_out_frame  = w_pick.frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (w_adv && r_do_shift && !r_hit && r_free) begin
            r_filled <= r_filled + FILL_W'(1);
        end
    end

    always_comb begin
        case (r_state)
            S_ACC:   n_state = w_acc ? S_UPD : S_ACC;
            S_UPD:   n_state = w_adv ? S_ACC : S_UPD;
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_key    <= n_out_key;
            r_out_frame  <= n_out_frame;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot       = r_out_slot;
    assign o_rsp.entry_key  = r_out_key;
    assign o_rsp.last_frame = r_out_frame;

    `LPSC_ASSERT_IMPL(a_sel_onehot, r_state == S_UPD, $onehot0(r_sel), "selected position not one-hot")
    `LPSC_ASSERT_IMPL(a_fill_count, 1'b1, $countones(w_valid) == r_filled, "valid bits disagree with fill count")
    `LPSC_ASSERT_IMPL(a_fill_bound, 1'b1, r_filled <= FILL_W'(CAPACITY), "fill count beyond capacity")
    `LPSC_ASSERT_NEXT(a_rsp_after_upd, w_adv, r_out_valid && (r_state == S_ACC), "shift without result beat")
endmodule
